// ----- sv/bset_pkg.sv -----
// Package for the blinking source event tracker.
// Holds shared types and fixed constants; no dependencies.
package bset_pkg;

  localparam int STAMP_W   = 16;
  localparam int CENTER_W  = 16;
  localparam int CERT_W    = 20;
  localparam int WEIGHT_W  = 15;   // full weight 16384 fits in 15 bits
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [4:0]  INTERVAL_TOL = 5'd31;      // error must stay below 32
  localparam logic [9:0]  MAX_DIST     = 10'd512;
  localparam logic [14:0] FULL_WEIGHT  = 15'd16384;
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [16:0] CERT_KEEP    = 17'd65472;
  localparam logic [16:0] CERT_DECAY   = 17'd61440;
  localparam logic [CERT_W-1:0] CERT_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MAX_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_TGT_0 = 3'd4,
    REG_TGT_1 = 3'd5,
    REG_TGT_2 = 3'd6,
    REG_TGT_3 = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,    // sweep stamp memory after reset
    ST_IDLE,
    ST_READ,     // stamp memory read in flight
    ST_INTV,     // interval ready; write back new stamp
    ST_TRK,      // per-tracker: gate and distance
    ST_MUL_X,    // center x blend
    ST_MUL_Y,    // center y blend
    ST_CERT,     // certainty update
    ST_EMIT      // stream out all tracker states
  } state_t;

endpackage

// ----- sv/bset_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module bset_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/blinking_source_event_tracker.sv -----
// Top level of the blinking source event tracker.
// Uses bset_pkg and bset_ram.
//
// Usage:
//   s_axis: one transaction per request. tuser: req_type[0] (0 event,
//   1 decay tick), polarity[1]. tdata: pixel_x, pixel_y, timestamp.
//   m_axis: one transaction per active tracker, in tracker order; tlast marks
//   the final tracker. tuser: tracker_index. tdata: center_x, center_y,
//   certainty.
//   cfg_*: plain register writes, issued only while no request is in flight.
// Sequence:
//   A tick is accepted, then gets a certainty step for each tracker. An
//   accepted event passes the accept, stamp read and stamp write-back
//   steps, then a gate step for each tracker plus x, y and certainty
//   steps for each tracker within tolerance, all sharing one 17x20
//   multiplier. A rejected event goes straight to output. Then one
//   result per cycle with a ready receiver.
// Reset:
//   rst clears trackers and the config registers; the stamp memory is then
//   swept to zero before s_tready rises.
// Stall:
//   Results are held while m_tready is low; no new request is taken until
//   all results of the current one have left.
module blinking_source_event_tracker
  import bset_pkg::*;
#(
  parameter int TIME_SHIFT   = 0,
  parameter int NUM_TRACKERS = 4,
  parameter int SENSOR_SIDE  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pixel_x[6:0], pixel_y[13:7], timestamp[45:14]
  input  logic [47:0] s_tdata,
  // req_type[0], polarity[1]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // center_x[15:0], center_y[31:16], certainty[51:32]
  output logic [55:0] m_tdata,
  // tracker_index[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int NT    = (NUM_TRACKERS < 4) ? NUM_TRACKERS : 4;
  localparam int TW    = (NT > 1) ? $clog2(NT) : 1;
  localparam int DEPTH = SENSOR_SIDE * SENSOR_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [TW-1:0] LAST_TRK = TW'(NT - 1);

  // configuration
  logic [6:0] min_x, max_x, min_y, max_y;
  logic [STAMP_W-1:0] target [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= '0; max_x <= 7'd127; min_y <= '0; max_y <= 7'd127;
      for (int i = 0; i < 4; i++) target[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_X: min_x <= cfg_data[6:0];
        REG_MAX_X: max_x <= cfg_data[6:0];
        REG_MIN_Y: min_y <= cfg_data[6:0];
        REG_MAX_Y: max_y <= cfg_data[6:0];
        REG_TGT_0: target[0] <= cfg_data;
        REG_TGT_1: target[1] <= cfg_data;
        REG_TGT_2: target[2] <= cfg_data;
        REG_TGT_3: target[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // tracker state
  logic [CENTER_W-1:0] cx [NT];
  logic [CENTER_W-1:0] cy [NT];
  logic [CERT_W-1:0]   cert [NT];

  state_t state, state_next;
  logic [AW:0]    clr_cnt;
  logic [TW-1:0]  trk;
  logic           is_tick;
  logic [6:0]     px_r, py_r;
  logic [STAMP_W-1:0] now_r, intv;
  logic [WEIGHT_W-1:0] fn;

  // input decode
  logic        in_req, in_pol;
  logic [6:0]  in_x, in_y;
  logic [31:0] in_ts;
  logic [47:0] ts_sh;
  assign in_req = s_tuser[0];
  assign in_pol = s_tuser[1];
  assign in_x   = s_tdata[6:0];
  assign in_y   = s_tdata[13:7];
  assign in_ts  = s_tdata[45:14];
  assign ts_sh  = {16'd0, in_ts} >> TIME_SHIFT;

  logic in_ok;
  assign in_ok = !in_pol && in_x >= min_x && in_x <= max_x && in_y >= min_y &&
                 in_y <= max_y && 32'(in_x) < SENSOR_SIDE && 32'(in_y) < SENSOR_SIDE;

  // stamp memory: read at accept, re-read from the held pixel while in flight
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr, pix_addr, in_addr;
  logic [STAMP_W-1:0] ram_wdata, ram_rdata;
  assign pix_addr  = AW'(32'(px_r) * SENSOR_SIDE + 32'(py_r));
  assign in_addr   = AW'(32'(in_x) * SENSOR_SIDE + 32'(in_y));
  assign ram_raddr = (state == ST_IDLE) ? in_addr : pix_addr;
  assign ram_we    = (state == ST_CLEAR) || (state == ST_INTV);
  assign ram_waddr = (state == ST_CLEAR) ? clr_cnt[AW-1:0] : pix_addr;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : now_r;

  bset_ram #(.WIDTH(STAMP_W), .DEPTH(DEPTH)) u_stamp (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // per-tracker gate and distance (narrow logic)
  logic [STAMP_W-1:0] tgt;
  logic [STAMP_W:0]   err_full;
  logic [4:0]         err;
  logic [9:0]         err_sq;
  logic [CENTER_W-1:0] cur_x, cur_y;
  logic [8:0]  dist_x, dist_y;
  logic        far;
  logic [10:0] cube_sum;
  logic [9:0]  dc;
  logic        gate;

  function automatic logic [8:0] fdist(input logic [15:0] c, input logic [6:0] p);
    logic [16:0] d;
    logic [8:0]  r;
    d = {1'b0, c} - {1'b0, p, 8'd0};
    if (!d[16]) r = {1'b0, d[15:8]};
    else r = 9'((({1'b0, p, 8'd0} - {1'b0, c}) + 17'd255) >> 8);
    return r;
  endfunction

  // cubes up to 8; anything farther is clipped anyway
  function automatic logic [9:0] cube_lut(input logic [3:0] a);
    logic [9:0] r;
    case (a)
      4'd0:    r = 10'd0;
      4'd1:    r = 10'd1;
      4'd2:    r = 10'd8;
      4'd3:    r = 10'd27;
      4'd4:    r = 10'd64;
      4'd5:    r = 10'd125;
      4'd6:    r = 10'd216;
      4'd7:    r = 10'd343;
      default: r = MAX_DIST;
    endcase
    return r;
  endfunction

  assign tgt      = target[trk];
  assign err_full = (tgt >= intv) ? {1'b0, tgt - intv} : {1'b0, intv - tgt};
  assign gate     = err_full <= {12'd0, INTERVAL_TOL};
  assign err      = err_full[4:0];
  assign err_sq   = err * err;
  assign cur_x    = cx[trk];
  assign cur_y    = cy[trk];
  assign dist_x   = fdist(cur_x, px_r);
  assign dist_y   = fdist(cur_y, py_r);
  assign far      = (dist_x > 9'd8) || (dist_y > 9'd8);
  assign cube_sum = 11'(cube_lut(dist_x[3:0])) + 11'(cube_lut(dist_y[3:0]));
  assign dc       = (far || cube_sum > 11'(MAX_DIST)) ? MAX_DIST : cube_sum[9:0];

  logic [15:0] fn_raw;
  assign fn_raw = 16'(FULL_WEIGHT) - 16'(err_sq) - 16'(dc);

  // blend: fo*c + fn*p = (c << 16) -/+ fn*|c - p|
  logic [CENTER_W-1:0] blend_c, blend_p, gap;
  logic                pull_down, blend_sub;
  assign blend_c   = (state == ST_MUL_Y) ? cur_y : cur_x;
  assign blend_p   = (state == ST_MUL_Y) ? {py_r, 8'd0} : {px_r, 8'd0};
  assign pull_down = blend_c > blend_p;
  assign gap       = pull_down ? blend_c - blend_p : blend_p - blend_c;
  assign blend_sub = ((state == ST_MUL_X) || (state == ST_MUL_Y)) && pull_down;

  // shared multiplier: 17 x 20 -> 37, plus addend
  logic [16:0] mul_a;
  logic [19:0] mul_b;
  logic [36:0] mul_p;
  logic [36:0] acc;
  assign mul_p = mul_a * mul_b;
  always_comb begin
    mul_a = '0; mul_b = '0; acc = '0;
    unique case (state) inside
      ST_MUL_X, ST_MUL_Y: begin
        mul_a = 17'(fn); mul_b = 20'(gap);
        acc = {5'd0, blend_c, 16'd0};
      end
      ST_CERT: begin
        mul_a = is_tick ? CERT_DECAY : CERT_KEEP; mul_b = cert[trk];
        acc = is_tick ? '0 : 37'({fn, 10'd0});
      end
      default: ;
    endcase
  end
  logic [36:0] sum;
  logic [20:0] cert_new;
  assign sum      = blend_sub ? acc - mul_p : acc + mul_p;
  assign cert_new = 21'(sum >> 16);

  // sequencer
  logic emit_done;
  assign emit_done = m_tvalid && m_tready && (trk == LAST_TRK);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:
        if (s_tvalid) begin
          if (in_req) state_next = ST_CERT;
          else if (in_ok) state_next = ST_READ;
          else state_next = ST_EMIT;
        end
      ST_READ:  state_next = ST_INTV;
      ST_INTV:  state_next = ST_TRK;
      ST_TRK:   state_next = gate ? ST_MUL_X : ((trk == LAST_TRK) ? ST_EMIT : ST_TRK);
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_CERT;
      ST_CERT:
        if (trk == LAST_TRK) state_next = ST_EMIT;
        else state_next = is_tick ? ST_CERT : ST_TRK;
      ST_EMIT:  if (emit_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      trk     <= '0;
      is_tick <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      unique case (state)
        ST_IDLE: begin
          trk <= '0;
          if (s_tvalid) is_tick <= in_req;
        end
        ST_TRK:  if (!gate) trk <= (trk == LAST_TRK) ? '0 : trk + 1'b1;
        ST_CERT: trk <= (trk == LAST_TRK) ? '0 : trk + 1'b1;
        ST_EMIT: if (m_tready) trk <= (trk == LAST_TRK) ? '0 : trk + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NT; i++) begin
        cx[i] <= '0; cy[i] <= '0; cert[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_MUL_X: cx[trk] <= sum[31:16];
        ST_MUL_Y: cy[trk] <= sum[31:16];
        ST_CERT:  cert[trk] <= cert_new[20] ? CERT_MAX : cert_new[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      px_r  <= in_x;
      py_r  <= in_y;
      now_r <= ts_sh[15:0];
    end
    if (state == ST_INTV) intv <= now_r - ram_rdata;
    if (state == ST_TRK) fn <= fn_raw[15] ? '0 : fn_raw[14:0];
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tlast  = (trk == LAST_TRK);
  assign m_tdata  = {4'd0, cert[trk], cy[trk], cx[trk]};
  assign m_tuser  = 2'(trk);

endmodule

// ----- sv/bset_checker.sv -----
// Port-level checker for the blinking source event tracker.
// Uses the top-level ports only; bound to the top level below.
module bset_props (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // no input taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken during output");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("result changed under stall");

  // after the last result the block returns to accept input
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready after last result");

  // a result presented straight after acceptance reports tracker zero
  a_first_idx: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!m_tvalid || m_tuser == 2'd0))
    else $error("bad first tracker index");

endmodule

bind blinking_source_event_tracker bset_props u_bset_props (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ----- tb/sv/bset_checker.sv -----
// Checker for the blinking source event tracker: watches both streams,
// predicts the tracker states and compares them. Depends on bset_pkg.
module bset_checker
  import bset_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  idx;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [19:0] cert;
    logic        last;
  } trk_state_t;

  trk_state_t  state_q[$];
  logic [6:0]  win_lo_x, win_hi_x, win_lo_y, win_hi_y;
  logic [15:0] tgt [4];
  logic [15:0] stamp_mem [16384];
  logic [15:0] pos_x [4];
  logic [15:0] pos_y [4];
  logic [19:0] cert [4];

  assign pending = state_q.size();

  // |floor((c - p) / 256)|
  function automatic longint cell_dist(longint c, longint p);
    longint d;
    d = c - p;
    if (d >= 0) return d >>> 8;
    return ((-d) + 255) >>> 8;
  endfunction

  task automatic blend(int n, longint intv, longint px, longint py);
    longint e, dx, dy, dxy, fn, fo, c;
    e = tgt[n] - intv;
    if (e < 0) e = -e;
    if (e >= 32) return;
    dx = cell_dist(pos_x[n], px);
    dy = cell_dist(pos_y[n], py);
    dxy = dx * dx * dx + dy * dy * dy;
    if (dxy > 512) dxy = 512;
    fn = 16384 - e * e - dxy;
    if (fn < 0) fn = 0;
    fo = 65536 - fn;
    pos_x[n] = 16'((fo * pos_x[n] + fn * px) >> 16);
    pos_y[n] = 16'((fo * pos_y[n] + fn * py) >> 16);
    c = (longint'(65472) * cert[n] + 1024 * fn) >> 16;
    cert[n] = (c > 20'hFFFFF) ? 20'hFFFFF : 20'(c);
  endtask

  task automatic predict_request(logic [47:0] d, logic [1:0] u);
    logic [6:0]  x, y;
    logic [15:0] now;
    longint      intv;
    trk_state_t  r;
    x = d[6:0];
    y = d[13:7];
    if (u[0]) begin
      for (int n = 0; n < 4; n++) cert[n] = 20'((longint'(61440) * cert[n]) >> 16);
    end else if (!u[1] && x >= win_lo_x && x <= win_hi_x &&
                 y >= win_lo_y && y <= win_hi_y) begin
      now = d[29:14];
      intv = 16'(now - stamp_mem[{x, y}]);
      stamp_mem[{x, y}] = now;
      for (int n = 0; n < 4; n++) blend(n, intv, longint'(x) << 8, longint'(y) << 8);
    end
    for (int n = 0; n < 4; n++) begin
      r.idx = 2'(n);
      r.cx = pos_x[n];
      r.cy = pos_y[n];
      r.cert = cert[n];
      r.last = (n == 3);
      state_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    trk_state_t want;
    int         errs;
    errs = 0;
    if (rst) begin
      win_lo_x = 0; win_hi_x = 127; win_lo_y = 0; win_hi_y = 127;
      for (int n = 0; n < 4; n++) begin
        tgt[n] = 0; pos_x[n] = 0; pos_y[n] = 0; cert[n] = 0;
      end
      for (int i = 0; i < 16384; i++) stamp_mem[i] = 0;
      state_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_X: win_lo_x = cfg_data[6:0];
          REG_MAX_X: win_hi_x = cfg_data[6:0];
          REG_MIN_Y: win_lo_y = cfg_data[6:0];
          REG_MAX_Y: win_hi_y = cfg_data[6:0];
          REG_TGT_0: tgt[0] = cfg_data;
          REG_TGT_1: tgt[1] = cfg_data;
          REG_TGT_2: tgt[2] = cfg_data;
          REG_TGT_3: tgt[3] = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_request(s_tdata, s_tuser);
      // compare one result transaction
      if (m_tvalid && m_tready) begin
        if (state_q.size() == 0) begin
          $error("unexpected result transaction %h", m_tdata);
          errs = errs + 1;
        end else begin
          want = state_q.pop_front();
          if (m_tuser !== want.idx) begin
            $error("tracker_index expected %0d actual %0d", want.idx, m_tuser);
            errs = errs + 1;
          end
          if (m_tdata[15:0] !== want.cx) begin
            $error("center_x expected %0d actual %0d", want.cx, m_tdata[15:0]);
            errs = errs + 1;
          end
          if (m_tdata[31:16] !== want.cy) begin
            $error("center_y expected %0d actual %0d", want.cy, m_tdata[31:16]);
            errs = errs + 1;
          end
          if (m_tdata[51:32] !== want.cert) begin
            $error("certainty expected %0d actual %0d", want.cert, m_tdata[51:32]);
            errs = errs + 1;
          end
          if (m_tlast !== want.last) begin
            $error("last expected %0d actual %0d", want.last, m_tlast);
            errs = errs + 1;
          end
        end
      end
    end
    if (rst) fail_count <= 0;
    else fail_count <= fail_count + errs;
  end

endmodule

// ----- tb/sv/blinking_source_event_tracker_tb.sv -----
// Testbench top for the blinking source event tracker: clock, reset,
// stimulus and verdict. Depends on bset_pkg, bset_checker and the block.
module blinking_source_event_tracker_tb
  import bset_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        s_tvalid, s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          no_idle;
  logic [6:0]  hot_x, hot_y;
  logic [15:0] blink_clock;

  blinking_source_event_tracker u_top (.*);

  bset_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // run limit: covers the stamp memory clearing sweep plus ~350 items
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stalls at random except while no_idle is set
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= no_idle || ($urandom_range(99) >= 29);
  end

  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send(logic typ, logic [6:0] x, logic [6:0] y, logic pol, logic [31:0] ts);
    while (!no_idle && $urandom_range(99) < 29) @(posedge clk);
    s_tvalid <= 1;
    s_tdata <= {2'b00, ts, y, x};
    s_tuser <= {pol, typ};
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // event at a hot pixel near a blinking target interval
  task automatic blink_event(logic [15:0] base);
    logic [6:0] x, y;
    x = hot_x + 7'($urandom_range(2));
    y = hot_y + 7'($urandom_range(2));
    blink_clock = blink_clock + base + 16'($urandom_range(40)) - 16'd20;
    send(0, x, y, $urandom_range(9) == 0, {16'($urandom), blink_clock});
  endtask

  task automatic random_phase(int count, logic [15:0] base);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       send(1, 0, 0, 0, $urandom);
        1, 2:    send(0, 7'($urandom), 7'($urandom), 1'($urandom), $urandom);
        default: blink_event(base);
      endcase
    end
  endtask

  initial begin
    rst <= 1;
    s_tvalid <= 0;
    s_tdata <= 0;
    s_tuser <= 0;
    cfg_we <= 0;
    cfg_index <= 0;
    cfg_data <= 0;
    no_idle = 0;
    blink_clock = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, field extremes, ticks, OFF events
    send(0, 0, 0, 0, 32'h0000_0000);
    send(0, 127, 127, 0, 32'hFFFF_FFFF);
    send(0, 127, 127, 0, 32'h0000_0000);
    send(0, 0, 0, 1, 32'hFFFF_FFFF);
    send(1, 127, 127, 1, 32'hFFFF_FFFF);
    settle();
    write_reg(REG_TGT_0, 16'd100);
    write_reg(REG_TGT_1, 16'd131);
    write_reg(REG_TGT_2, 16'd69);
    write_reg(REG_TGT_3, 16'hFFFF);
    write_reg(REG_MIN_X, 10);
    write_reg(REG_MAX_X, 20);
    write_reg(REG_MIN_Y, 30);
    write_reg(REG_MAX_Y, 40);
    send(0, 15, 35, 0, 32'd1000);
    send(0, 15, 35, 0, 32'd1100);   // exact match tracker 0
    send(0, 15, 35, 0, 32'd1231);   // edge of tolerance
    send(0, 15, 35, 0, 32'd1263);   // out of tolerance for every tracker
    send(0, 9, 35, 0, 32'd1400);    // outside window
    send(0, 21, 41, 0, 32'd1500);
    send(0, 20, 40, 0, 32'd1500);
    send(0, 20, 40, 0, 32'd1499);   // wraps to 0xFFFF
    send(0, 10, 30, 1, 32'd1600);   // OFF
    send(1, 0, 0, 0, 0);
    settle();
    // empty window
    write_reg(REG_MIN_X, 50);
    write_reg(REG_MAX_X, 49);
    send(0, 50, 35, 0, 32'd100);
    send(0, 49, 35, 0, 32'd200);
    settle();

    // random phases with blink targets and varied windows
    write_reg(REG_MIN_X, 40);
    write_reg(REG_MAX_X, 90);
    write_reg(REG_MIN_Y, 40);
    write_reg(REG_MAX_Y, 90);
    write_reg(REG_TGT_0, 16'd500);
    write_reg(REG_TGT_1, 16'd510);
    write_reg(REG_TGT_2, 16'd530);
    write_reg(REG_TGT_3, 16'd1000);
    hot_x = 60; hot_y = 70;
    random_phase(110, 16'd505);
    no_idle = 1;
    random_phase(60, 16'd505);
    no_idle = 0;
    settle();
    write_reg(REG_MIN_X, 0);
    write_reg(REG_MAX_X, 127);
    write_reg(REG_MIN_Y, 0);
    write_reg(REG_MAX_Y, 127);
    write_reg(REG_TGT_0, 16'd65530);
    write_reg(REG_TGT_1, 16'd0);
    write_reg(REG_TGT_2, 16'd65500);
    write_reg(REG_TGT_3, 16'd65535);
    hot_x = 125; hot_y = 0;
    random_phase(80, 16'd65530);
    settle();
    write_reg(REG_TGT_0, 16'd300);
    write_reg(REG_TGT_1, 16'd320);
    write_reg(REG_MIN_Y, 127);
    write_reg(REG_MAX_Y, 127);
    hot_x = 3; hot_y = 127;
    random_phase(80, 16'd310);
    settle();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
